// ===== rtl/pdps_pkg.sv =====
package pdps_pkg;

  // Field widths of the request and the result.
  localparam int unsigned FreqW = 28;
  localparam int unsigned ClkW  = 28;
  localparam int unsigned PscW  = 14;
  localparam int unsigned RldW  = 28;

  // Rounded period count and its rounded root (the root can reach 2^14).
  localparam int unsigned QW    = 28;
  localparam int unsigned RootW = 15;

  // Serial divider: dividend holds 2*clk + f, divisor holds 2*f.
  localparam int unsigned DvdW = 30;
  localparam int unsigned DvsW = 29;
  localparam int unsigned CntW = 5;

  // Register port.
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;
  localparam logic [AddrW-3:0] RegTimerClk = '0;
  localparam logic [ClkW-1:0]  ClkReset    = 28'd72000000;

  // Highest even bit position of the period count, where the root search starts.
  localparam logic [QW-1:0] RootBitInit = 28'h4000000;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DvdW-1:0] quotient;
    logic [DvsW-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== rtl/pdps_if.sv =====
interface pdps_req_if;
  logic                        valid;
  logic                        ready;
  logic [pdps_pkg::FreqW-1:0]  target_freq_hz;

  modport source (output valid, output target_freq_hz, input ready);
  modport sink (input valid, input target_freq_hz, output ready);
endinterface

interface pdps_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [pdps_pkg::PscW-1:0]  prescale;
  logic [pdps_pkg::RldW-1:0]  reload;
  logic                       invalid;

  modport source (output valid, output prescale, output reload, output invalid, input ready);
  modport sink (input valid, input prescale, input reload, input invalid, output ready);
endinterface

// ===== rtl/pdps_regs.sv =====
module pdps_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pdps_pkg::AddrW-1:0]  paddr,
  input  logic [pdps_pkg::DataW-1:0]  pwdata,
  output logic [pdps_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output logic [pdps_pkg::ClkW-1:0]   timer_clock_hz_o
);
  import pdps_pkg::*;

  logic [ClkW-1:0] timer_clock_hz_q;
  logic            sel_clk;

  // Word decode; the byte offset within a word is ignored.
  assign sel_clk = (paddr[AddrW-1:2] == RegTimerClk);

  // Timer clock register, written in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_clock_hz_q <= ClkReset;
    end else if (psel && penable && pwrite && sel_clk) begin
      timer_clock_hz_q <= pwdata[ClkW-1:0];
    end
  end

  assign prdata           = sel_clk ? {{(DataW-ClkW){1'b0}}, timer_clock_hz_q} : '0;
  assign pready           = 1'b1;
  assign timer_clock_hz_o = timer_clock_hz_q;

endmodule

// ===== rtl/pdps_divider.sv =====
module pdps_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pdps_pkg::div_req_t  req_i,
  output pdps_pkg::div_rsp_t  rsp_o
);
  import pdps_pkg::*;

  localparam logic [CntW-1:0] LastStep = CntW'(DvdW - 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DvdW-1:0] dq_q;
  logic [DvsW-1:0] rem_q;
  logic [DvsW-1:0] dvs_q;
  logic [DvsW:0]   shifted;
  logic [DvsW:0]   trial;
  logic            fits;

  // One restoring step: bring down the next dividend bit and try the subtract.
  assign shifted = {rem_q, dq_q[DvdW-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = (shifted >= {1'b0, dvs_q});

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Working registers; the quotient bits shift in behind the dividend bits.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dq_q  <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DvdW-2:0], fits};
      rem_q <= fits ? trial[DvsW-1:0] : shifted[DvsW-1:0];
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dq_q;
  assign rsp_o.remainder = rem_q;

  // A new division is only started on an idle divider.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  // The last step always reports completion next cycle.
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && cnt_q == LastStep) |=> (done_q && !busy_q))
    else $error("divider missed its completion");

  // Completion is never reported while a division runs.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");

endmodule

// ===== rtl/pwm_divider_pair_solver_core.sv =====
// Channel    Dir  Beat payload                      Accepted when
// req_i      in   target_freq_hz                    valid && ready
// rsp_o      out  prescale, reload, invalid         valid && ready
// APB        in   timer_clock_hz at byte address 0  psel && penable && pwrite
//
// One request at a time; every division runs on one serial restoring divider.
// A request first divides for the period count, then takes the rounded root
// bit by bit, then divides by trial divisors until one fits.
// A zero request skips the divider; a result may wait in its output
// register while the next request is accepted. Reset clears all control state.
module pwm_divider_pair_solver_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pdps_pkg::AddrW-1:0]  paddr,
  input  logic [pdps_pkg::DataW-1:0]  pwdata,
  output logic [pdps_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  pdps_req_if.sink                    req_i,
  pdps_rsp_if.source                  rsp_o
);
  import pdps_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StQuot,
    StRoot,
    StTrial,
    StFinish
  } state_e;

  state_e           state_q;
  div_req_t         div_req_q;
  div_rsp_t         div_rsp;
  logic [ClkW-1:0]  timer_clock_hz;
  logic [QW-1:0]    q_q;
  logic [QW-1:0]    v_q;
  logic [QW-1:0]    res_q;
  logic [QW-1:0]    bit_q;
  logic [RootW-1:0] p_q;
  logic [PscW-1:0]  psc_q;
  logic [RldW-1:0]  rld_q;
  logic             inv_q;
  logic             out_valid_q;
  logic [PscW-1:0]  out_psc_q;
  logic [RldW-1:0]  out_rld_q;
  logic             out_inv_q;
  logic [QW-1:0]    root_sum;
  logic             root_fit;
  logic [QW-1:0]    v_nxt;
  logic [QW-1:0]    res_nxt;
  logic [RootW-1:0] root_r;

  pdps_regs u_regs (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .timer_clock_hz_o (timer_clock_hz)
  );

  pdps_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // One step of the bit-by-bit square root; the rounding compares the
  // leftover against the root, since q > r*r + r exactly when it exceeds r.
  assign root_sum = res_q + bit_q;
  assign root_fit = (v_q >= root_sum);
  assign v_nxt    = root_fit ? (v_q - root_sum) : v_q;
  assign res_nxt  = root_fit ? ((res_q >> 1) + bit_q) : (res_q >> 1);
  assign root_r   = res_nxt[RootW-1:0] + RootW'(v_nxt > res_nxt);

  // Sequencer and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      div_req_q   <= '0;
      q_q         <= '0;
      v_q         <= '0;
      res_q       <= '0;
      bit_q       <= '0;
      p_q         <= '0;
      psc_q       <= '0;
      rld_q       <= '0;
      inv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_psc_q   <= '0;
      out_rld_q   <= '0;
      out_inv_q   <= 1'b0;
    end else begin
      div_req_q.start <= 1'b0;
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (req_i.valid) begin
            if (req_i.target_freq_hz == '0) begin
              psc_q   <= '0;
              rld_q   <= '0;
              inv_q   <= 1'b1;
              state_q <= StFinish;
            end else begin
              div_req_q.start    <= 1'b1;
              div_req_q.dividend <= {1'b0, timer_clock_hz, 1'b0}
                                    + {2'b00, req_i.target_freq_hz};
              div_req_q.divisor  <= {req_i.target_freq_hz, 1'b0};
              state_q            <= StQuot;
            end
          end
        end
        StQuot: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient == '0) begin
              psc_q   <= '0;
              rld_q   <= '0;
              inv_q   <= 1'b1;
              state_q <= StFinish;
            end else begin
              q_q     <= div_rsp.quotient[QW-1:0];
              v_q     <= div_rsp.quotient[QW-1:0];
              res_q   <= '0;
              bit_q   <= RootBitInit;
              state_q <= StRoot;
            end
          end
        end
        StRoot: begin
          v_q   <= v_nxt;
          res_q <= res_nxt;
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            p_q                <= root_r;
            div_req_q.start    <= 1'b1;
            div_req_q.dividend <= {{(DvdW-QW){1'b0}}, q_q};
            div_req_q.divisor  <= {{(DvsW-RootW){1'b0}}, root_r};
            state_q            <= StTrial;
          end
        end
        StTrial: begin
          // Walk the divisor down until it divides the period count.
          if (div_rsp.done) begin
            if (div_rsp.remainder == '0 || p_q == RootW'(1)) begin
              psc_q   <= p_q[PscW-1:0];
              rld_q   <= div_rsp.quotient[RldW-1:0];
              inv_q   <= 1'b0;
              state_q <= StFinish;
            end else begin
              p_q                <= p_q - 1'b1;
              div_req_q.start    <= 1'b1;
              div_req_q.divisor  <= {{(DvsW-RootW){1'b0}}, p_q - 1'b1};
            end
          end
        end
        StFinish: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            out_psc_q   <= psc_q;
            out_rld_q   <= rld_q;
            out_inv_q   <= inv_q;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign req_i.ready    = (state_q == StIdle);
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.prescale = out_psc_q;
  assign rsp_o.reload   = out_rld_q;
  assign rsp_o.invalid  = out_inv_q;

  // An accepted request always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q != StIdle))
    else $error("request accepted but sequencer stayed idle");

  // A valid result has a nonzero divisor and period.
  a_valid_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.invalid) |-> (rsp_o.prescale != '0 && rsp_o.reload != '0))
    else $error("valid result with zero field");

  // A flagged result carries zero fields.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.invalid) |-> (rsp_o.prescale == '0 && rsp_o.reload == '0))
    else $error("invalid result with nonzero field");

  // The trial divisor never reaches zero.
  a_trial_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTrial) |-> (p_q != '0))
    else $error("trial divisor reached zero");

endmodule

// ===== dv/pwm_divider_pair_solver_core_test.sv =====
`timescale 1ns / 100ps

module pwm_divider_pair_solver_core_test;
  import pdps_pkg::*;

  // Trial divisors allowed per random request; keeps each search short.
  localparam int unsigned MaxTrialSpan = 300;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int unsigned QuietLimit   = 2_000_000;
  // Cycles to watch for stray results once everything has arrived.
  localparam int unsigned SettleCycles = 200;

  typedef struct packed {
    logic [PscW-1:0] prescale;
    logic [RldW-1:0] reload;
    logic            invalid;
  } divider_pair_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrW-1:0]     paddr;
  logic [DataW-1:0]     pwdata;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  pdps_req_if req_bus ();
  pdps_rsp_if rsp_bus ();

  pwm_divider_pair_solver_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus)
  );

  // Shadow of the timer clock register, changed only while the block is idle.
  logic [ClkW-1:0]  clk_rate_shadow;
  logic [FreqW-1:0] pending_freqs[$];
  divider_pair_t    expected_pairs[$];
  int unsigned      error_count;
  int unsigned      quiet_cycles;
  int unsigned      burst_left;
  int unsigned      gap_left;
  logic [15:0]      stall_pattern;
  int unsigned      pattern_age;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Rounded period count, rounded root, then a downward search for a divisor.
  function automatic divider_pair_t solve_pair(input logic [ClkW-1:0] clk_hz,
                                               input logic [FreqW-1:0] freq_hz,
                                               output int unsigned span);
    longint unsigned clk_wide;
    longint unsigned freq_wide;
    longint unsigned period;
    longint unsigned root;
    longint unsigned divisor;
    divider_pair_t   pair;
    pair = '{prescale: '0, reload: '0, invalid: 1'b1};
    span = 0;
    clk_wide = clk_hz;
    freq_wide = freq_hz;
    if (freq_wide == 0) return pair;
    period = (2 * clk_wide + freq_wide) / (2 * freq_wide);
    if (period == 0) return pair;
    // Exact floor of the root, then round half up.
    root = $rtoi($sqrt(real'(period)));
    while (root * root > period) root--;
    while ((root + 1) * (root + 1) <= period) root++;
    if (period > root * root + root) root++;
    divisor = root;
    while (divisor > 1 && (period % divisor) != 0) divisor--;
    pair.prescale = PscW'(divisor);
    pair.reload   = RldW'(period / divisor);
    pair.invalid  = 1'b0;
    span = int'(root - divisor);
    return pair;
  endfunction

  // Mix of raw values, small and large quotients, and rounding-half requests.
  function automatic logic [FreqW-1:0] pick_freq(input logic [ClkW-1:0] clk_hz);
    int unsigned     sel;
    int unsigned     target;
    longint unsigned clk_wide;
    clk_wide = clk_hz;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      return FreqW'($urandom());
    end else if (sel < 70) begin
      target = $urandom_range(1, 3000);
      return FreqW'(clk_wide / target + $urandom_range(0, 2));
    end else if (sel < 90) begin
      target = $urandom_range(1, 1 << 20);
      return FreqW'(clk_wide / target);
    end
    target = $urandom_range(0, 500);
    return FreqW'((2 * clk_wide) / (2 * target + 1) + $urandom_range(0, 1));
  endfunction

  task automatic queue_random_freqs(input int unsigned count);
    logic [FreqW-1:0] freq;
    int unsigned      span;
    divider_pair_t    unused;
    repeat (count) begin
      do begin
        freq = pick_freq(clk_rate_shadow);
        unused = solve_pair(clk_rate_shadow, freq, span);
      end while (span > MaxTrialSpan);
      pending_freqs.push_back(freq);
    end
  endtask

  // Setup and access cycle; returns at a falling edge so queue updates are race free.
  task automatic write_timer_clock(input logic [DataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegTimerClk, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    clk_rate_shadow = value[ClkW-1:0];
  endtask

  task automatic wait_for_idle();
    while (pending_freqs.size() != 0 || req_bus.valid || expected_pairs.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    error_count++;
    if (error_count <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid          <= 1'b0;
      req_bus.target_freq_hz <= '0;
      burst_left             <= 1;
      gap_left               <= 0;
    end else if (!req_bus.valid || req_bus.ready) begin
      if (gap_left != 0 || pending_freqs.size() == 0) begin
        req_bus.valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        req_bus.valid          <= 1'b1;
        req_bus.target_freq_hz <= pending_freqs.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          case ($urandom_range(0, 2))
            0:       gap_left <= 0;
            1:       gap_left <= $urandom_range(1, 20);
            default: gap_left <= $urandom_range(1, 1500);
          endcase
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Result receiver: ready follows a rotating pattern that is reloaded now and then.
  always @(posedge clk_i or negedge rst_ni) begin : stall_gen
    logic [15:0] fresh;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      stall_pattern <= 16'hFFFF;
      pattern_age   <= 0;
    end else begin
      rsp_bus.ready <= stall_pattern[0];
      if (pattern_age == 63) begin
        pattern_age <= 0;
        fresh = 16'($urandom());
        case ($urandom_range(0, 3))
          0:       stall_pattern <= 16'hFFFF;
          1:       stall_pattern <= 16'h0001;
          default: stall_pattern <= (fresh == 16'h0000) ? 16'hFFFF : fresh;
        endcase
      end else begin
        pattern_age   <= pattern_age + 1;
        stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
    end
  end

  // Monitor: checks each result beat first, then records the prediction for a new request.
  always @(posedge clk_i) begin : beat_monitor
    divider_pair_t want;
    int unsigned   span;
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_pairs.size() == 0) begin
          flag_mismatch("unexpected result, reload", 0, rsp_bus.reload);
        end else begin
          want = expected_pairs.pop_front();
          if (rsp_bus.prescale !== want.prescale)
            flag_mismatch("prescale", want.prescale, rsp_bus.prescale);
          if (rsp_bus.reload !== want.reload)
            flag_mismatch("reload", want.reload, rsp_bus.reload);
          if (rsp_bus.invalid !== want.invalid)
            flag_mismatch("invalid", want.invalid, rsp_bus.invalid);
        end
      end
      if (req_bus.valid && req_bus.ready)
        expected_pairs.push_back(solve_pair(clk_rate_shadow, req_bus.target_freq_hz, span));
    end
  end

  // Watchdog on cycles with no accepted beat on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk_i                  = 1'b0;
    rst_ni                 = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    req_bus.valid          = 1'b0;
    req_bus.target_freq_hz = '0;
    rsp_bus.ready          = 1'b0;
    clk_rate_shadow        = ClkReset;
    error_count            = 0;
    quiet_cycles           = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset clock rate: zero request, largest quotient, halves that round up,
    // a prime quotient that falls through to one, and root rounding cases.
    pending_freqs.push_back(28'd0);
    pending_freqs.push_back(28'd1);
    pending_freqs.push_back(28'hFFFFFFF);
    pending_freqs.push_back(28'd144000000);
    pending_freqs.push_back(28'd144000001);
    pending_freqs.push_back(28'd48000000);
    pending_freqs.push_back(28'd10285714);
    pending_freqs.push_back(28'd6000000);
    pending_freqs.push_back(28'd5538462);
    pending_freqs.push_back(28'd72000000);
    pending_freqs.push_back(28'd1000);
    pending_freqs.push_back(28'd20000);
    pending_freqs.push_back(28'h5555555);
    pending_freqs.push_back(28'h0AAAAAA);
    pending_freqs.push_back(28'hAAAAAAA);
    // Hold off until every result is back before the random part.
    wait_for_idle();
    queue_random_freqs(20);
    wait_for_idle();

    // Slowest timer clock: quotients of one or zero only.
    write_timer_clock(32'd1);
    pending_freqs.push_back(28'd1);
    pending_freqs.push_back(28'd2);
    pending_freqs.push_back(28'd3);
    pending_freqs.push_back(28'd0);
    pending_freqs.push_back(28'hFFFFFFF);
    queue_random_freqs(15);
    wait_for_idle();

    // Fastest timer clock in range.
    write_timer_clock(32'd200000000);
    pending_freqs.push_back(28'd1);
    pending_freqs.push_back(28'd200000000);
    pending_freqs.push_back(28'hFFFFFFF);
    queue_random_freqs(20);
    wait_for_idle();

    // Timer clock of zero: every request is invalid.
    write_timer_clock(32'd0);
    pending_freqs.push_back(28'd1);
    pending_freqs.push_back(28'd0);
    pending_freqs.push_back(28'hFFFFFFF);
    queue_random_freqs(5);
    wait_for_idle();

    // All bits set on the bus; the register keeps its low 28 bits.
    write_timer_clock(32'hFFFFFFFF);
    pending_freqs.push_back(28'd1);
    pending_freqs.push_back(28'd16385);
    queue_random_freqs(20);
    wait_for_idle();

    // A random clock rate within range.
    write_timer_clock(DataW'($urandom_range(1, 200000000)));
    queue_random_freqs(20);
    wait_for_idle();

    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
